/* design/lfs_pkg.sv */
package lfs_pkg;

  // Fixed field widths
  localparam int THR_W    = 10;
  localparam int SPEED_W  = 8;
  localparam int GAIN_W   = 6;
  localparam int CFG_W    = 10;
  localparam int CFG_A_W  = 3;
  localparam int ERR_W    = 4;
  localparam int CNT_W    = 4;
  localparam int SUM_W    = 5;
  localparam int MAG_W    = 4;
  localparam int PROD_W   = 11;
  localparam int OUT_W    = 24;

  localparam int CENTER_IDX = 3;

  // Register indexes
  localparam logic [CFG_A_W-1:0] REG_THRESHOLD    = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_CRUISE_SPEED = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_STEER_GAIN   = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_SEARCH       = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_FAST         = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_GAP_LIMIT    = 3'd5;

  // Register reset values
  localparam logic [THR_W-1:0]   RST_THRESHOLD    = 10'd512;
  localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED = 8'd90;
  localparam logic [GAIN_W-1:0]  RST_STEER_GAIN   = 6'd25;
  localparam logic [SPEED_W-1:0] RST_SEARCH       = 8'd120;
  localparam logic [SPEED_W-1:0] RST_FAST         = 8'd180;
  localparam logic [SPEED_W-1:0] RST_GAP_LIMIT    = 8'd15;

  localparam logic [SPEED_W-1:0] DUTY_MAX = 8'd255;

  typedef struct packed {
    logic                    hit;
    logic signed [ERR_W-1:0] weight;
  } lane_res_t;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [SUM_W-1:0] sum;
  } merge_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MERGE,
    S_START,
    S_WAIT,
    S_MULT,
    S_DRIVE
  } state_t;

endpackage

/* design/lfs_lane.sv */
module lfs_lane
  import lfs_pkg::*;
#(
  parameter int LANE_IDX    = 0,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [THR_W-1:0]       threshold,
  output lane_res_t              res
);

  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam logic signed [ERR_W-1:0] WEIGHT = ERR_W'(LANE_IDX - CENTER_IDX);

  lane_res_t res_r;
  lane_res_t res_nxt;
  logic      hit;

  // Compare one sample against the shared threshold
  always_comb begin
    hit            = CMP_W'(sample) > CMP_W'(threshold);
    res_nxt.hit    = hit;
    res_nxt.weight = hit ? WEIGHT : '0;
  end

  // Hold the lane result for the merge stage
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

/* design/lfs_merge.sv */
module lfs_merge
  import lfs_pkg::*;
#(
  parameter int SENSOR_COUNT = 8
) (
  input  logic                         clk,
  input  logic                         load,
  input  lane_res_t [SENSOR_COUNT-1:0] lanes,
  output merge_res_t                   res
);

  merge_res_t res_r;
  merge_res_t res_nxt;

  // Count the hits and add the weights of all lanes
  always_comb begin
    res_nxt.count = '0;
    res_nxt.sum   = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      res_nxt.count = res_nxt.count + CNT_W'(lanes[i].hit);
      res_nxt.sum   = res_nxt.sum
                    + {{(SUM_W-ERR_W){lanes[i].weight[ERR_W-1]}}, lanes[i].weight};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

/* design/lfs_div.sv */
module lfs_div
  import lfs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]        divisor,
  output logic                    done,
  output logic signed [ERR_W-1:0] quotient
);

  localparam int STEP_W = $clog2(MAG_W + 1);

  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [MAG_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  dvs_r;
  logic              neg_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SUM_W-1:0]  mag;
  logic [CNT_W:0]    trial;

  // One restoring step per cycle on the magnitudes
  always_comb begin
    mag      = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    trial    = {rem_r, quo_r[MAG_W-1]};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = mag[MAG_W-1:0];
      step_nxt = STEP_W'(MAG_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = CNT_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CNT_W-1:0];
        quo_nxt = {quo_r[MAG_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
      neg_r <= dividend[SUM_W-1];
    end
  end

  // Restore the sign, truncating toward zero
  assign done     = done_r;
  assign quotient = neg_r ? ERR_W'(-quo_r) : ERR_W'(quo_r);

endmodule

/* design/line_follower_steering_core.sv */
// Channel | Dir | Handshake          | Payload
// in_     | in  | in_tvalid/tready   | in_tdata: one frame of sensor samples
// out_    | out | out_tvalid/tready  | out_tdata: wheel drives, out_tuser: line found
// cfg_    | in  | cfg_we             | cfg_addr register index, cfg_wdata value
//
// A frame seen on the line passes the merge, the four divider steps, the multiply and
// the drive stage; a frame with no sensor on the line goes from the merge straight to
// the drive stage. One frame is in work at a time; the drive stage
// stalls while the output register still holds a result that out_tready has not taken.
// rst_n is synchronous and active low; it loads the register defaults and
// clears the turn memory and the lost-frame count.
module line_follower_steering_core
  import lfs_pkg::*;
#(
  parameter int SENSOR_COUNT = 8,
  parameter int SAMPLE_BITS  = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // sample_0 .. sample_N-1, SAMPLE_BITS each, from the lowest bit up
  input  logic [((SENSOR_COUNT*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // left_reverse, left_duty, right_reverse, right_duty, position_error
  output logic [OUT_W-1:0]     out_tdata,
  // line_found
  output logic                 out_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_we,
  input  logic [CFG_A_W-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Configuration registers
  logic [THR_W-1:0]   thr_r;
  logic [SPEED_W-1:0] base_r;
  logic [GAIN_W-1:0]  gain_r;
  logic [SPEED_W-1:0] search_r;
  logic [SPEED_W-1:0] fast_r;
  logic [SPEED_W-1:0] gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= RST_THRESHOLD;
      base_r   <= RST_CRUISE_SPEED;
      gain_r   <= RST_STEER_GAIN;
      search_r <= RST_SEARCH;
      fast_r   <= RST_FAST;
      gap_r    <= RST_GAP_LIMIT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_THRESHOLD:    thr_r    <= cfg_wdata[THR_W-1:0];
        REG_CRUISE_SPEED: base_r   <= cfg_wdata[SPEED_W-1:0];
        REG_STEER_GAIN:   gain_r   <= cfg_wdata[GAIN_W-1:0];
        REG_SEARCH:       search_r <= cfg_wdata[SPEED_W-1:0];
        REG_FAST:         fast_r   <= cfg_wdata[SPEED_W-1:0];
        REG_GAP_LIMIT:    gap_r    <= cfg_wdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  logic   in_acc;
  logic   merge_load;
  logic   div_start;
  logic   mult_load;
  logic   drive_load;

  assign in_acc = in_tvalid && in_tready;

  // Sensor lanes
  lane_res_t [SENSOR_COUNT-1:0] lanes;

  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
    lfs_lane #(
      .LANE_IDX    (g),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk       (clk),
      .load      (in_acc),
      .sample    (in_tdata[g*SAMPLE_BITS +: SAMPLE_BITS]),
      .threshold (thr_r),
      .res       (lanes[g])
    );
  end

  merge_res_t merged;

  lfs_merge #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_merge (
    .clk   (clk),
    .load  (merge_load),
    .lanes (lanes),
    .res   (merged)
  );

  logic                    div_done;
  logic signed [ERR_W-1:0] div_quo;

  lfs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (merged.sum),
    .divisor  (merged.count),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Error and steering product
  logic signed [ERR_W-1:0]  err_r;
  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (div_done) begin
      err_r <= div_quo;
    end
    if (mult_load) begin
      prod_r <= PROD_W'(err_r * $signed({1'b0, gain_r}));
    end
  end

  // Drive split and saturation
  logic signed [PROD_W-1:0] left_v, right_v;
  logic [PROD_W-1:0]        left_mag, right_mag;
  logic [SPEED_W-1:0]       left_duty, right_duty;
  logic                     lost;
  logic [SPEED_W-1:0]       lost_inc;
  logic [SPEED_W-1:0]       spin_mag;

  always_comb begin
    left_v    = $signed(PROD_W'(base_r)) - prod_r;
    right_v   = $signed(PROD_W'(base_r)) + prod_r;
    left_mag  = left_v[PROD_W-1] ? PROD_W'(-left_v) : PROD_W'(left_v);
    right_mag = right_v[PROD_W-1] ? PROD_W'(-right_v) : PROD_W'(right_v);
    left_duty  = (left_mag > PROD_W'(DUTY_MAX)) ? DUTY_MAX : left_mag[SPEED_W-1:0];
    right_duty = (right_mag > PROD_W'(DUTY_MAX)) ? DUTY_MAX : right_mag[SPEED_W-1:0];
  end

  // Turn memory and lost-frame count
  logic               turn_left_r, turn_left_nxt;
  logic [SPEED_W-1:0] lost_cnt_r, lost_cnt_nxt;

  always_comb begin
    lost     = (merged.count == '0);
    lost_inc = (lost_cnt_r == DUTY_MAX) ? lost_cnt_r : lost_cnt_r + 1'b1;
    spin_mag = (lost_inc > gap_r) ? fast_r : search_r;
  end

  // Output register
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic             out_user_r, out_user_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Sequence one frame through lanes, merge, divider, multiply and drive; a lost frame skips the divider
  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    merge_load    = 1'b0;
    div_start     = 1'b0;
    mult_load     = 1'b0;
    drive_load    = 1'b0;
    turn_left_nxt = turn_left_r;
    lost_cnt_nxt  = lost_cnt_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        merge_load = 1'b1;
        state_nxt  = S_START;
      end
      S_START: begin
        if (lost) begin
          state_nxt = S_DRIVE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_done) begin
          state_nxt = S_MULT;
        end
      end
      S_MULT: begin
        mult_load = 1'b1;
        state_nxt = S_DRIVE;
      end
      S_DRIVE: begin
        if (!out_valid_r || out_tready) begin
          drive_load    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (lost) begin
            lost_cnt_nxt = lost_inc;
            out_user_nxt = 1'b0;
            out_data_nxt = {2'b00, {ERR_W{1'b0}}, spin_mag, !turn_left_r,
                            spin_mag, turn_left_r};
          end else begin
            lost_cnt_nxt = '0;
            if (err_r < -$signed(ERR_W'(1))) begin
              turn_left_nxt = 1'b1;
            end else if (err_r > $signed(ERR_W'(1))) begin
              turn_left_nxt = 1'b0;
            end
            out_user_nxt = 1'b1;
            out_data_nxt = {2'b00, err_r, right_duty, right_v[PROD_W-1],
                            left_duty, left_v[PROD_W-1]};
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      turn_left_r <= 1'b0;
      lost_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      turn_left_r <= turn_left_nxt;
      lost_cnt_r  <= lost_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (drive_load) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

  // A lost-line result spins in place with a zero error
  a_lost_spin : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |->
      (out_tdata[21:18] == '0 && out_tdata[0] != out_tdata[9]))
    else $error("lost-line result is not a spin with zero error");

  // The lost-frame count only steps up by one or clears
  a_lost_cnt : assert property (@(posedge clk) disable iff (!rst_n)
    (lost_cnt_r != $past(lost_cnt_r)) |->
      (lost_cnt_r == '0 || lost_cnt_r == $past(lost_cnt_r) + 1'b1))
    else $error("lost-frame count jumped");

  // The divider finishes only while the sequencer waits for it
  a_div_done : assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_WAIT))
    else $error("divider finished outside the wait state");

  // A tracked error is no lower than the smallest sensor weight
  a_err_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      ($signed(out_tdata[21:18]) >= -4'sd3))
    else $error("position error out of range");

endmodule
